@@ rtl/qpsh_pkg.sv @@
// ----------------------------------------------------------------------------
// qpsh_pkg - shared types and constants of the quadratic probe hash table
// Beat formats of both channels, status codes, state encodings and the fixed
// widths of the key hash datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package qpsh_pkg;

	localparam int LOW_W        = 64;
	localparam int HIGH_W       = 48;
	localparam int KEY_W        = LOW_W + HIGH_W;
	localparam int MAX_KEY_BYTES = 14;
	localparam int BYTE_CNT_W   = 4;
	localparam int SLOT_W       = 7;
	localparam int ACC_W        = 5;

	localparam int HASH_MUL     = 19;
	localparam int PROBE_LIN    = 23;

	// byte sum of a 14 byte key stays below 2^15, times 19 below 2^19
	localparam int SUM_W        = 15;
	localparam int BASE_W       = 19;
	// remainder unit works on 4 bits of the base per cycle
	localparam int MOD_DIGIT    = 4;
	localparam int MOD_STEPS    = 5;
	localparam int SH_W         = MOD_DIGIT * MOD_STEPS;
	localparam int STEP_CNT_W   = 3;

	typedef enum logic [2:0] {
		ST_INSERTED  = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_NO_FREE   = 3'd2,
		ST_REMOVED   = 3'd3,
		ST_NOT_FOUND = 3'd4
	} status_t;

	typedef enum logic {
		ACT_INSERT = 1'b0,
		ACT_REMOVE = 1'b1
	} action_t;

	typedef struct packed {
		action_t             action;
		logic [LOW_W-1:0]    key_low;
		logic [HIGH_W-1:0]   key_high;
	} req_t;

	typedef struct packed {
		logic [SLOT_W-1:0]   slot;
		status_t             status;
		logic [ACC_W-1:0]    accesses;
	} rsp_t;

	typedef enum logic [1:0] {
		H_IDLE,
		H_SUM,
		H_MUL,
		H_MOD
	} hash_state_t;

	typedef enum logic [2:0] {
		T_CLEAR,
		T_IDLE,
		T_HASH,
		T_READ,
		T_PROBE,
		T_FIN
	} top_state_t;

endpackage

`default_nettype wire

@@ rtl/qpsh_hash.sv @@
// ----------------------------------------------------------------------------
// qpsh_hash - key canonicalization and home slot computation
// Cuts the key at its first zero byte, sums byte*(position+1) one byte per
// cycle, scales by 19 and reduces modulo the table size four bits a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module qpsh_hash #(
	parameter int TABLE_SIZE = 101,
	parameter int KEY_BYTES  = 14
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic [qpsh_pkg::LOW_W-1:0]             key_low,
	input  logic [qpsh_pkg::HIGH_W-1:0]            key_high,
	output logic [qpsh_pkg::KEY_W-1:0]             ckey,
	output logic                                   done,
	output logic [$clog2(TABLE_SIZE)-1:0]          home
);
	import qpsh_pkg::*;

	localparam int IDX_W = $clog2(TABLE_SIZE);
	localparam logic [IDX_W:0] SIZE_X = (IDX_W+1)'(TABLE_SIZE);
	localparam logic [BYTE_CNT_W-1:0] LAST_BYTE = BYTE_CNT_W'(KEY_BYTES - 1);
	localparam logic [STEP_CNT_W-1:0] LAST_STEP = STEP_CNT_W'(MOD_STEPS - 1);

	function automatic logic [KEY_W-1:0] canonical_key(input logic [KEY_W-1:0] raw,
		input int nbytes);
		logic [KEY_W-1:0] res;
		logic             alive;
		res   = '0;
		alive = 1'b1;
		for (int i = 0; i < MAX_KEY_BYTES; i++) begin
			alive = alive && (i < nbytes) && (raw[i*8 +: 8] != 8'd0);
			if (alive) begin
				res[i*8 +: 8] = raw[i*8 +: 8];
			end
		end
		return res;
	endfunction

	hash_state_t             state_q, state_d;
	logic [KEY_W-1:0]        ckey_q;
	logic [SUM_W-1:0]        sum_q;
	logic [BYTE_CNT_W-1:0]   cnt_q;
	logic [SH_W-1:0]         sh_q;
	logic [IDX_W-1:0]        r_q, r_next;
	logic [STEP_CNT_W-1:0]   step_q;
	logic [7:0]              cur_byte;
	logic [11:0]             prod;

	assign cur_byte = ckey_q[{cnt_q, 3'b000} +: 8];
	assign prod     = 12'(cur_byte) * 12'(cnt_q + 4'd1);

	// four restoring remainder steps on the top digit of the shift register
	always_comb begin
		logic [IDX_W:0]   t;
		logic [IDX_W-1:0] r;
		r = r_q;
		for (int k = 0; k < MOD_DIGIT; k++) begin
			t = {r, sh_q[SH_W-1-k]};
			if (t >= SIZE_X) begin
				t = t - SIZE_X;
			end
			r = t[IDX_W-1:0];
		end
		r_next = r;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			H_IDLE: if (start) state_d = H_SUM;
			H_SUM:  if (cnt_q == LAST_BYTE) state_d = H_MUL;
			H_MUL:  state_d = H_MOD;
			H_MOD:  if (step_q == LAST_STEP) state_d = H_IDLE;
			default: state_d = H_IDLE;
		endcase
	end

	always_comb begin
		done = 1'b0;
		unique case (state_q)
			H_MOD:   done = (step_q == LAST_STEP);
			default: done = 1'b0;
		endcase
	end

	assign home = r_next;
	assign ckey = ckey_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= H_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			H_IDLE: begin
				if (start) begin
					ckey_q <= canonical_key({key_high, key_low}, KEY_BYTES);
					sum_q  <= '0;
					cnt_q  <= '0;
				end
			end
			H_SUM: begin
				sum_q <= sum_q + SUM_W'(prod);
				cnt_q <= cnt_q + 1'b1;
			end
			H_MUL: begin
				sh_q   <= SH_W'(BASE_W'(sum_q * HASH_MUL));
				r_q    <= '0;
				step_q <= '0;
			end
			H_MOD: begin
				sh_q   <= sh_q << MOD_DIGIT;
				r_q    <= r_next;
				step_q <= step_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/quadratic_probe_string_hash_table_unit.sv @@
// ----------------------------------------------------------------------------
// quadratic_probe_string_hash_table_unit - open addressed table of short keys
// Inserts or removes one key per request beat and returns one response beat.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_stall/req_data): action plus a 14 byte key,
//   zero padded. rsp channel (rsp_valid/rsp_stall/rsp_data): slot, status
//   and access count. A beat moves when valid is high and stall is low.
//   One key is processed at a time; req_stall stays high while busy.
//   The number of table slots examined per request runs from 1 to
//   MAX_PROBES + 1. The next request is taken in the cycle after the
//   response is loaded. The processing time is set by the byte-serial
//   key sum, the 4-bit-per-cycle remainder unit and one table read per
//   probed slot on the single read port.
//   After reset the table memory is cleared one slot per cycle with
//   req_stall high.
//   A stalled response is held in the output register; the block can take
//   and process the next request meanwhile and then waits to hand it over.
// ----------------------------------------------------------------------------
`default_nettype none

module quadratic_probe_string_hash_table_unit #(
	parameter int TABLE_SIZE = 101,
	parameter int MAX_PROBES = 21,
	parameter int KEY_BYTES  = 14
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  qpsh_pkg::req_t req_data,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output qpsh_pkg::rsp_t rsp_data
);
	import qpsh_pkg::*;

	localparam int IDX_W = $clog2(TABLE_SIZE);
	localparam int J_W   = $clog2(MAX_PROBES + 1);
	localparam logic [IDX_W:0]   SIZE_X   = (IDX_W+1)'(TABLE_SIZE);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);
	localparam logic [IDX_W-1:0] D_FIRST  = IDX_W'((1 + PROBE_LIN) % TABLE_SIZE);
	localparam logic [IDX_W-1:0] D_STEP   = IDX_W'(2 % TABLE_SIZE);
	localparam logic [J_W-1:0]   LAST_J   = J_W'(MAX_PROBES);

	top_state_t        state_q, state_d;
	logic [IDX_W-1:0]  clr_q;
	logic [IDX_W-1:0]  addr_q, d_q, next_addr, next_d;
	logic [J_W-1:0]    j_q;
	action_t           act_q;
	rsp_t              res_q, rsp_q;
	logic              rsp_valid_q;

	logic              accept, hash_start, hash_done, res_load;
	logic [IDX_W-1:0]  hash_home;
	logic [KEY_W-1:0]  ckey;

	logic [KEY_W-1:0]  mem_q [TABLE_SIZE];
	logic [KEY_W-1:0]  rd_data_q, wr_data;
	logic [IDX_W-1:0]  rd_addr, wr_addr;
	logic              wr_en;

	logic              dec_done, dec_write;
	rsp_t              dec_res;

	assign accept = req_valid && !req_stall;

	qpsh_hash #(
		.TABLE_SIZE (TABLE_SIZE),
		.KEY_BYTES  (KEY_BYTES)
	) u_hash (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (hash_start),
		.key_low  (req_data.key_low),
		.key_high (req_data.key_high),
		.ckey     (ckey),
		.done     (hash_done),
		.home     (hash_home)
	);

	// next probe slot: increments 24, 26, 28, ... all kept reduced mod size
	always_comb begin
		logic [IDX_W:0] sa;
		logic [IDX_W:0] sd;
		sa = {1'b0, addr_q} + {1'b0, d_q};
		if (sa >= SIZE_X) begin
			sa = sa - SIZE_X;
		end
		sd = {1'b0, d_q} + {1'b0, D_STEP};
		if (sd >= SIZE_X) begin
			sd = sd - SIZE_X;
		end
		next_addr = sa[IDX_W-1:0];
		next_d    = sd[IDX_W-1:0];
	end

	// decide on the slot whose contents sit in rd_data_q
	always_comb begin
		logic             empty, equal, at_home, last;
		logic [ACC_W-1:0] acc_hit;
		empty   = (rd_data_q[7:0] == 8'd0);
		equal   = (rd_data_q == ckey);
		at_home = (j_q == '0);
		last    = (j_q == LAST_J);
		acc_hit = at_home ? ACC_W'(1) : ACC_W'(j_q - 1'b1);

		dec_done         = 1'b0;
		dec_write        = 1'b0;
		dec_res.slot     = '0;
		dec_res.status   = ST_NOT_FOUND;
		dec_res.accesses = '0;

		unique case (act_q)
			ACT_INSERT: begin
				priority if (empty) begin
					dec_done         = 1'b1;
					dec_write        = 1'b1;
					dec_res.slot     = SLOT_W'(addr_q);
					dec_res.status   = ST_INSERTED;
					dec_res.accesses = acc_hit;
				end else if (at_home && equal) begin
					dec_done       = 1'b1;
					dec_res.slot   = SLOT_W'(addr_q);
					dec_res.status = ST_DUPLICATE;
				end else if (last) begin
					dec_done       = 1'b1;
					dec_res.status = ST_NO_FREE;
				end else begin
					dec_done = 1'b0;
				end
			end
			ACT_REMOVE: begin
				priority if (at_home && empty) begin
					dec_done       = 1'b1;
					dec_res.status = ST_NOT_FOUND;
				end else if (equal) begin
					dec_done         = 1'b1;
					dec_write        = 1'b1;
					dec_res.slot     = SLOT_W'(addr_q);
					dec_res.status   = ST_REMOVED;
					dec_res.accesses = acc_hit;
				end else if (last) begin
					dec_done       = 1'b1;
					dec_res.status = ST_NOT_FOUND;
				end else begin
					dec_done = 1'b0;
				end
			end
			default: dec_done = 1'b0;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			T_CLEAR: if (clr_q == LAST_IDX) state_d = T_IDLE;
			T_IDLE:  if (req_valid) state_d = T_HASH;
			T_HASH:  if (hash_done) state_d = T_READ;
			T_READ:  state_d = T_PROBE;
			T_PROBE: if (dec_done) state_d = T_FIN;
			T_FIN:   if (!rsp_valid_q || !rsp_stall) state_d = T_IDLE;
			default: state_d = T_IDLE;
		endcase
	end

	always_comb begin
		req_stall  = 1'b1;
		hash_start = 1'b0;
		wr_en      = 1'b0;
		wr_addr    = addr_q;
		wr_data    = '0;
		rd_addr    = addr_q;
		res_load   = 1'b0;
		unique case (state_q)
			T_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
			end
			T_IDLE: begin
				req_stall  = 1'b0;
				hash_start = req_valid;
			end
			T_HASH: begin
				rd_addr = addr_q;
			end
			T_READ: begin
				rd_addr = addr_q;
			end
			T_PROBE: begin
				rd_addr = next_addr;
				wr_en   = dec_write;
				wr_data = (act_q == ACT_INSERT) ? ckey : '0;
			end
			T_FIN: begin
				res_load = !rsp_valid_q || !rsp_stall;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_CLEAR;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == T_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (res_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= req_data.action;
		end
		if (state_q == T_HASH && hash_done) begin
			addr_q <= hash_home;
			d_q    <= D_FIRST;
			j_q    <= '0;
		end
		if (state_q == T_PROBE) begin
			if (dec_done) begin
				res_q <= dec_res;
			end else begin
				addr_q <= next_addr;
				d_q    <= next_d;
				j_q    <= j_q + 1'b1;
			end
		end
		if (res_load) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

`default_nettype wire

@@ rtl/qpsh_checker.sv @@
// ----------------------------------------------------------------------------
// qpsh_checker - port level checks of the hash table unit
// Watches both channels and the response fields over time.
// ----------------------------------------------------------------------------
`default_nettype none

module qpsh_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_stall,
	input  logic           rsp_valid,
	input  logic           rsp_stall,
	input  qpsh_pkg::rsp_t rsp_data
);
	import qpsh_pkg::*;

	// a stalled response beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
		else $error("response beat changed while stalled");

	// one key in flight: after a request beat the block is busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while a key is in flight");

	// a miss reports neither slot nor accesses
	a_miss: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_data.status == ST_NO_FREE || rsp_data.status == ST_NOT_FOUND)
		|-> rsp_data.slot == '0 && rsp_data.accesses == '0)
		else $error("miss with nonzero slot or accesses");

	// a duplicate is found at home with no access counted
	a_dup: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.status == ST_DUPLICATE |-> rsp_data.accesses == '0)
		else $error("duplicate with nonzero accesses");

endmodule

bind quadratic_probe_string_hash_table_unit qpsh_checker u_qpsh_checker (.*);

`default_nettype wire
